// ===== src/header_sync_frame_checksum_parser_macros.svh =====
// assertion macros shared by the parser rtl
`ifndef HEADER_SYNC_FRAME_CHECKSUM_PARSER_MACROS_SVH
`define HEADER_SYNC_FRAME_CHECKSUM_PARSER_MACROS_SVH

// property must hold at every clock edge out of reset
`define HSFCP_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("hsfcp assertion failed");

// consequent must hold in the cycle after the antecedent
`define HSFCP_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hsfcp assertion failed");

`endif

// ===== src/hsfcp_pkg.sv =====
// types and constants of the sync header frame parser
package hsfcp_pkg;

  localparam logic [7:0] SyncFirst  = 8'hAA;
  localparam logic [7:0] SyncSecond = 8'h55;

  // parse state codes
  localparam logic [1:0] ModeHunt1 = 2'd0;
  localparam logic [1:0] ModeHunt2 = 2'd1;
  localparam logic [1:0] ModeBody  = 2'd2;

  localparam logic [7:0] FirstBodyPos = 8'd2;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic [7:0] byte_position;
    logic       frame_last;
    logic       checksum_ok;
  } result_t;

endpackage

// ===== src/hsfcp_in_stage.sv =====
// input register stage holding one received byte
`include "header_sync_frame_checksum_parser_macros.svh"

module hsfcp_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          rx_byte_i,
  output hsfcp_pkg::item_t    item_o,
  input  logic                take_i
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       accept;

  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    if (accept) begin
      valid_d = 1'b1;
      byte_d  = rx_byte_i;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign item_o.valid = valid_q;
  assign item_o.data  = byte_q;

  // a held item that the parser did not take stays put
  `HSFCP_ASSERT_NEXT(a_held_item_stays, valid_q && !take_i, valid_q && $stable(byte_q))

endmodule

// ===== src/hsfcp_parser.sv =====
// sync hunt, frame position and checksum logic with result register
`include "header_sync_frame_checksum_parser_macros.svh"

module hsfcp_parser #(
  parameter int FRAME_BYTES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hsfcp_pkg::item_t    item_i,
  output logic                take_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hsfcp_pkg::result_t  result_o
);

  localparam logic [7:0] LastPos = 8'(FRAME_BYTES - 1);

  logic [1:0]         mode_q, mode_d;
  logic [7:0]         count_q, count_d;
  logic [7:0]         sum_q, sum_d;
  logic               out_valid_q, out_valid_d;
  hsfcp_pkg::result_t res_q, res_d;
  logic               emit;
  logic               is_last;
  logic               bad_second_sync;

  // an item moves on once the result slot is free or being emptied
  assign take_o  = item_i.valid && (!out_valid_q || !out_stall_i);
  assign is_last = count_q >= LastPos;

  assign bad_second_sync = take_o && (mode_q == hsfcp_pkg::ModeHunt2) &&
                           (item_i.data != hsfcp_pkg::SyncSecond);

  always_comb begin
    mode_d  = mode_q;
    count_d = count_q;
    sum_d   = sum_q;
    emit    = 1'b0;
    res_d.frame_byte    = item_i.data;
    res_d.byte_position = count_q;
    res_d.frame_last    = is_last;
    res_d.checksum_ok   = is_last && (sum_q == item_i.data);
    if (take_o) begin
      unique case (mode_q)
        hsfcp_pkg::ModeHunt2: begin
          if (item_i.data == hsfcp_pkg::SyncSecond) begin
            mode_d  = hsfcp_pkg::ModeBody;
            count_d = hsfcp_pkg::FirstBodyPos;
            sum_d   = hsfcp_pkg::SyncFirst + hsfcp_pkg::SyncSecond;
          end else begin
            mode_d  = hsfcp_pkg::ModeHunt1;
            count_d = '0;
            sum_d   = '0;
          end
        end
        hsfcp_pkg::ModeBody: begin
          emit = 1'b1;
          if (is_last) begin
            mode_d  = hsfcp_pkg::ModeHunt1;
            count_d = '0;
            sum_d   = '0;
          end else begin
            count_d = count_q + 8'd1;
            sum_d   = sum_q + item_i.data;
          end
        end
        default: begin
          // unused code behaves as hunting the first sync byte
          mode_d  = (item_i.data == hsfcp_pkg::SyncFirst) ? hsfcp_pkg::ModeHunt2
                                                          : hsfcp_pkg::ModeHunt1;
          count_d = '0;
          sum_d   = '0;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (take_o) begin
      out_valid_d = emit;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= hsfcp_pkg::ModeHunt1;
      count_q     <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  `HSFCP_ASSERT(a_last_at_end, out_valid_q && res_q.frame_last |-> res_q.byte_position == LastPos)
  `HSFCP_ASSERT(a_ok_only_on_last, out_valid_q && !res_q.frame_last |-> !res_q.checksum_ok)
  `HSFCP_ASSERT(a_body_pos_range, out_valid_q |-> res_q.byte_position >= hsfcp_pkg::FirstBodyPos)
  `HSFCP_ASSERT_NEXT(a_bad_sync_rehunt, bad_second_sync, mode_q == hsfcp_pkg::ModeHunt1)

endmodule

// ===== src/header_sync_frame_checksum_parser.sv =====
// Sync header frame parser. Each item is one received byte. The parser hunts
// for the sync pair AA then 55, then emits every following byte of a
// FRAME_BYTES long frame with its position (2 .. FRAME_BYTES-1). The final
// byte is flagged as last and carries checksum_ok: the 8-bit sum of all
// earlier frame bytes, sync bytes included, equals it. Sync bytes give no
// result, and hunting resumes right after the final byte. One item is taken
// every cycle while the output is not stalled; a result is presented in the
// cycle after its byte is taken (the byte sits in the input register, the
// parse step loads the result register at the next edge), together with the
// update of the parse state (mode, position count, running sum).
// A stalled result holds the byte behind it in the input register.

module header_sync_frame_checksum_parser #(
  parameter int FRAME_BYTES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] frame_byte_o,
  output logic [7:0] byte_position_o,
  output logic       frame_last_o,
  output logic       checksum_ok_o
);

  hsfcp_pkg::item_t   item;
  hsfcp_pkg::result_t result;
  logic               take;

  hsfcp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .item_o     (item),
    .take_i     (take)
  );

  hsfcp_parser #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result)
  );

  assign frame_byte_o    = result.frame_byte;
  assign byte_position_o = result.byte_position;
  assign frame_last_o    = result.frame_last;
  assign checksum_ok_o   = result.checksum_ok;

endmodule

// ===== verif/tb.sv =====
// testbench for the sync header frame parser: frame stream stimulus against a parse-state tracker
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FrameBytes  = 16;
  localparam int DrainCycles = 10;
  localparam int HoldCycles  = 300;
  localparam int MaxReports  = 10;

  // tracks the parse state and keeps the results still owed by the block
  class frame_parse_tracker;
    logic [1:0]         mode;
    logic [7:0]         pos_count;
    logic [7:0]         sum;
    hsfcp_pkg::result_t owed[$];
    int                 fails;

    function new();
      mode      = hsfcp_pkg::ModeHunt1;
      pos_count = '0;
      sum       = '0;
      fails     = 0;
    endfunction

    function void restart_hunt();
      mode      = hsfcp_pkg::ModeHunt1;
      pos_count = '0;
      sum       = '0;
    endfunction

    function void note_rx_byte(logic [7:0] b);
      hsfcp_pkg::result_t r;
      logic [7:0]         last_pos;
      logic               is_last;
      last_pos = 8'(FrameBytes - 1);
      case (mode)
        hsfcp_pkg::ModeHunt2: begin
          // a wrong second sync byte is dropped, not looked at again
          if (b == hsfcp_pkg::SyncSecond) begin
            mode      = hsfcp_pkg::ModeBody;
            pos_count = hsfcp_pkg::FirstBodyPos;
            sum       = hsfcp_pkg::SyncFirst + hsfcp_pkg::SyncSecond;
          end else begin
            restart_hunt();
          end
        end
        hsfcp_pkg::ModeBody: begin
          is_last         = (pos_count >= last_pos);
          r.frame_byte    = b;
          r.byte_position = pos_count;
          r.frame_last    = is_last;
          r.checksum_ok   = is_last && (sum == b);
          owed.push_back(r);
          if (is_last) begin
            restart_hunt();
          end else begin
            sum       = sum + b;
            pos_count = pos_count + 8'd1;
          end
        end
        default: begin
          mode      = (b == hsfcp_pkg::SyncFirst) ? hsfcp_pkg::ModeHunt2
                                                  : hsfcp_pkg::ModeHunt1;
          pos_count = '0;
          sum       = '0;
        end
      endcase
    endfunction

    function void check_frame_result(hsfcp_pkg::result_t got);
      hsfcp_pkg::result_t want;
      if (owed.size() == 0) begin
        fails++;
        if (fails <= MaxReports) begin
          $display("unexpected result: byte %h pos %0d last %b ok %b", got.frame_byte,
                   got.byte_position, got.frame_last, got.checksum_ok);
        end
        return;
      end
      want = owed.pop_front();
      if (got.frame_byte !== want.frame_byte || got.byte_position !== want.byte_position ||
          got.frame_last !== want.frame_last || got.checksum_ok !== want.checksum_ok) begin
        fails++;
        if (fails <= MaxReports) begin
          $display("result differs: byte %h/%h pos %0d/%0d last %b/%b ok %b/%b (exp/got)",
                   want.frame_byte, got.frame_byte, want.byte_position, got.byte_position,
                   want.frame_last, got.frame_last, want.checksum_ok, got.checksum_ok);
        end
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] rx_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] frame_byte_o;
  logic [7:0] byte_position_o;
  logic       frame_last_o;
  logic       checksum_ok_o;

  int send_idle_pct = 37;
  int recv_idle_pct = 51;
  int hold_request  = 0;
  int items_sent    = 0;

  frame_parse_tracker tracker = new();

  header_sync_frame_checksum_parser #(
    .FRAME_BYTES(FrameBytes)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_byte_o   (frame_byte_o),
    .byte_position_o(byte_position_o),
    .frame_last_o   (frame_last_o),
    .checksum_ok_o  (checksum_ok_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // receiver side: random stalls, or one long hold-off when asked
  initial begin : receiver
    int held;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request > 0) begin
        held = hold_request;
        out_stall_i <= 1'b1;
        repeat (held - 1) @(negedge clk_i);
        hold_request = 0;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o && !out_stall_i) begin
      tracker.check_frame_result({frame_byte_o, byte_position_o, frame_last_o, checksum_ok_o});
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.note_rx_byte(b);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_frame(input logic good_sum);
    logic [7:0] acc;
    logic [7:0] body;
    send_byte(hsfcp_pkg::SyncFirst);
    send_byte(hsfcp_pkg::SyncSecond);
    acc = hsfcp_pkg::SyncFirst + hsfcp_pkg::SyncSecond;
    for (int i = 2; i < FrameBytes - 1; i++) begin
      body = 8'($urandom);
      send_byte(body);
      acc = acc + body;
    end
    send_byte(good_sum ? acc : acc ^ 8'($urandom_range(1, 255)));
  endtask

  task automatic send_random_until(input int target);
    int pick;
    int n;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        send_frame($urandom_range(99) < 70);
      end else if (pick < 80) begin
        // broken sync: first byte right, second wrong (sometimes another first byte)
        send_byte(hsfcp_pkg::SyncFirst);
        if ($urandom_range(1) == 0) begin
          send_byte(hsfcp_pkg::SyncFirst);
        end else begin
          send_byte(8'($urandom_range(0, 84)) + ($urandom_range(1) ? 8'd0 : 8'd86));
        end
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) send_byte($urandom_range(3) == 0 ? hsfcp_pkg::SyncFirst : 8'($urandom));
      end
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    rx_byte_i  = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // extremes, sync bytes out of place, wrong second sync byte, one clean frame
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(hsfcp_pkg::SyncFirst);
    send_byte(hsfcp_pkg::SyncFirst);
    send_byte(hsfcp_pkg::SyncSecond);
    send_byte(hsfcp_pkg::SyncFirst);
    send_byte(8'h00);
    send_frame(1'b1);

    send_random_until(560);
    send_idle_pct = 51;
    recv_idle_pct = 37;
    send_random_until(1100);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_until(1200);
    // long receiver hold-off while items keep coming
    hold_request = HoldCycles;
    send_random_until(1600);
    in_valid_i <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (tracker.fails == 0 && tracker.pending() == 0) begin
      $display("header_sync_frame_checksum_parser: match");
    end else begin
      $display("header_sync_frame_checksum_parser: mismatch");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("header_sync_frame_checksum_parser: mismatch");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/hsfcp_pkg.sv
src/hsfcp_in_stage.sv
src/hsfcp_parser.sv
src/header_sync_frame_checksum_parser.sv
verif/tb.sv
